// File: hw/rtl/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg
// shared types and constants of the triangle minimum path sum block
// ----------------------------------------------------------------------------
`default_nettype none

package tmps_pkg;

    localparam int SUM_W = 22;
    localparam int CFG_W = 7;

    typedef logic signed [SUM_W-1:0] t_sum;

    localparam t_sum SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam t_sum SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // per-beat position flags, fixed at acceptance
    typedef struct packed {
        logic col0;
        logic row_end;
        logic last_row;
    } t_item_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/triangle_min_path_sum.sv
// result: a triangle's last entry passes the stage-1 register, then the output register
// throughput: one entry per cycle unless the result stalls; each entry is one row memory
// read-modify-write; a just-written sum is forwarded if the next entry reads its cell
// reset: synchronous, active low; clears sequencer, running sums and handshakes,
// sets the row count to one; the row memory is not cleared (every cell is written first)
// ----------------------------------------------------------------------------
// triangle_min_path_sum
// streamed minimum top-to-bottom path sum of a number triangle
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_min_path_sum #(
    parameter int MAX_ROWS    = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] i_entry_value,
    input  wire logic                          i_cfg_we,
    input  wire logic [tmps_pkg::CFG_W-1:0]    i_cfg_wdata,
    output      logic                          o_valid,
    input  wire logic                          i_ready,
    output      tmps_pkg::t_sum                o_min_sum
);
    import tmps_pkg::*;

    localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic                          accept;
    logic [IW-1:0]                 col;
    t_item_ctl                     ctl;
    t_sum                          rdata;
    t_sum                          above;
    t_sum                          best;
    t_sum                          result;
    logic                          s1_final;
    logic                          s1_go;

    logic                          r_s1_valid;
    t_item_ctl                     r_s1_ctl;
    logic [IW-1:0]                 r_s1_col;
    logic signed [VALUE_WIDTH-1:0] r_s1_value;
    logic                          r_fwd;
    t_sum                          r_fwd_data;
    logic                          r_out_valid;
    t_sum                          r_out_sum;

    assign accept   = i_valid && o_ready;
    assign s1_final = r_s1_ctl.row_end && r_s1_ctl.last_row;
    assign s1_go    = r_s1_valid && (!s1_final || !r_out_valid || i_ready);
    assign o_ready  = !r_s1_valid || s1_go;
    assign above    = r_fwd ? r_fwd_data : rdata;

    tmps_ctl #(
        .MAX_ROWS (MAX_ROWS),
        .IW       (IW)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .o_col       (col),
        .o_ctl       (ctl)
    );

    tmps_row_mem #(
        .DEPTH (MAX_ROWS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (col),
        .o_rdata (rdata),
        .i_we    (s1_go),
        .i_waddr (r_s1_col),
        .i_wdata (best)
    );

    tmps_acc #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (s1_go),
        .i_value  (r_s1_value),
        .i_above  (above),
        .i_ctl    (r_s1_ctl),
        .o_best   (best),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl   <= ctl;
            r_s1_col   <= col;
            r_s1_value <= i_entry_value;
            r_fwd      <= s1_go && (r_s1_col == col);
            r_fwd_data <= best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_final) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_final) begin
            r_out_sum <= result;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_min_sum = r_out_sum;

endmodule

`default_nettype wire

// File: hw/rtl/tmps_ctl.sv
// ----------------------------------------------------------------------------
// tmps_ctl
// row count register and row / column sequencer for incoming beats
// ----------------------------------------------------------------------------
`default_nettype none

module tmps_ctl #(
    parameter int MAX_ROWS = 64,
    parameter int IW       = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [tmps_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                       i_accept,
    output      logic [IW-1:0]              o_col,
    output      tmps_pkg::t_item_ctl        o_ctl
);
    import tmps_pkg::*;

    localparam int CW = ((IW + 1) > CFG_W) ? (IW + 1) : CFG_W;

    logic [CFG_W-1:0] r_row_count;
    logic [IW-1:0]    r_row_idx;
    logic [IW-1:0]    r_col;
    logic [CW-1:0]    cnt;
    logic [CW-1:0]    rows_eff;

    always_comb begin
        cnt = CW'(r_row_count);
        if (cnt == '0) begin
            rows_eff = CW'(1);
        end else if (cnt > CW'(MAX_ROWS)) begin
            rows_eff = CW'(MAX_ROWS);
        end else begin
            rows_eff = cnt;
        end
    end

    assign o_col          = r_col;
    assign o_ctl.col0     = (r_col == '0);
    assign o_ctl.row_end  = (r_col >= r_row_idx);
    assign o_ctl.last_row = ((CW'(r_row_idx) + CW'(1)) >= rows_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_row_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_idx <= '0;
            r_col     <= '0;
        end else if (i_accept) begin
            if (o_ctl.row_end) begin
                r_col <= '0;
                if (o_ctl.last_row) begin
                    r_row_idx <= '0;
                end else begin
                    r_row_idx <= r_row_idx + IW'(1);
                end
            end else begin
                r_col <= r_col + IW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tmps_row_mem.sv
// ----------------------------------------------------------------------------
// tmps_row_mem
// row buffer of best path sums, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tmps_row_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic           i_clk,
    input  wire logic           i_re,
    input  wire logic [AW-1:0]  i_raddr,
    output      tmps_pkg::t_sum o_rdata,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire tmps_pkg::t_sum i_wdata
);
    import tmps_pkg::*;

    t_sum r_mem [DEPTH];
    t_sum r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/tmps_acc.sv
// ----------------------------------------------------------------------------
// tmps_acc
// best-sum update with saturation, left neighbour and bottom row minimum
// ----------------------------------------------------------------------------
`default_nettype none

module tmps_acc #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_go,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    input  wire tmps_pkg::t_sum                i_above,
    input  wire tmps_pkg::t_item_ctl           i_ctl,
    output      tmps_pkg::t_sum                o_best,
    output      tmps_pkg::t_sum                o_result
);
    import tmps_pkg::*;

    localparam int EW = ((VALUE_WIDTH > SUM_W) ? VALUE_WIDTH : SUM_W) + 1;

    t_sum                r_left;
    t_sum                r_bottom;
    t_sum                above_eff;
    t_sum                pick;
    logic signed [EW-1:0] sum_raw;

    assign above_eff = i_ctl.row_end ? '0 : i_above;

    always_comb begin
        if (i_ctl.col0) begin
            pick = above_eff;
        end else if (i_ctl.row_end) begin
            pick = r_left;
        end else begin
            pick = (r_left < above_eff) ? r_left : above_eff;
        end
        sum_raw = EW'(i_value) + EW'(pick);
        if (sum_raw > EW'(SUM_MAX)) begin
            o_best = SUM_MAX;
        end else if (sum_raw < EW'(SUM_MIN)) begin
            o_best = SUM_MIN;
        end else begin
            o_best = SUM_W'(sum_raw);
        end
    end

    assign o_result = (o_best < r_bottom) ? o_best : r_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_bottom <= SUM_MAX;
        end else if (i_go) begin
            r_left <= i_ctl.row_end ? '0 : above_eff;
            if (i_ctl.last_row) begin
                r_bottom <= i_ctl.row_end ? SUM_MAX : o_result;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tmps_chk.sv
// ----------------------------------------------------------------------------
// tmps_chk
// port-level checks of the triangle minimum path sum block
// ----------------------------------------------------------------------------
`default_nettype none

module tmps_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           o_ready,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire tmps_pkg::t_sum o_min_sum
);
    import tmps_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_min_sum)))
        else $error("result beat changed while stalled");

    // a new result follows an accepted input beat
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result beat without a matching input beat");

    // with no result pending the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output stage");

endmodule

bind triangle_min_path_sum tmps_chk u_tmps_chk (.*);

`default_nettype wire
